FILE: hdl/lce_pkg.sv
// shared widths and defaults for the lis count engine
package lce_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 32;
    localparam int LENGTH_W    = 11;
    localparam int MAX_LEN_DEF = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

FILE: hdl/lce_if.sv
// valid/ready channel interfaces for the input and result words
interface lce_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lce_pkg::VALUE_W-1:0]   value;
    logic                                 last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lce_out_if;
    logic                            valid;
    logic                            ready;
    logic [lce_pkg::COUNT_W-1:0]     lis_count;
    logic [lce_pkg::LENGTH_W-1:0]    lis_length;
    logic                            count_saturated;
    logic                            too_long;

    modport source (output valid, output lis_count, output lis_length,
                    output count_saturated, output too_long, input ready);
    modport sink   (input valid, input lis_count, input lis_length,
                    input count_saturated, input too_long, output ready);
endinterface

FILE: hdl/lce_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lis_count_engine.sv
// top level of the lis count engine: scan, accumulate and result register
//
// Counts the longest strictly increasing subsequences of a stream of signed
// 32-bit words. Input channel i_in carries value and last; result channel
// o_out carries lis_count, lis_length, count_saturated and too_long, one word
// per sequence, issued after the word marked last.
// Each element is stored in one ram (value, length, count). A new element
// reads every earlier entry, one per cycle through the ram's read port, and
// is then written into the ram; the next element is not accepted before
// this one is through. The scan is skipped when nothing is stored yet, and
// an element that finds the store full is dropped without scan or write.
// The result word is registered once the last element is through; the scan
// loop over the stored entries sets the rate.
// Counts clamp at 2^32-1 and raise count_saturated; elements beyond MAX_LEN
// are dropped and raise too_long. After a result the engine starts afresh.
// Reset is synchronous and clears the fill position, the running best and
// the flags; ram contents need no clearing.
// The result sits in an output register; a new element is accepted while it
// waits, and a second result stalls the engine until the first is taken.
module lis_count_engine #(
    parameter int MAX_LEN = lce_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lce_in_if.sink     i_in,
    lce_out_if.source  o_out
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam int LEN_W  = FILL_W;
    localparam int WORD_W = lce_pkg::VALUE_W + LEN_W + lce_pkg::COUNT_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_LEN);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    function automatic logic [lce_pkg::COUNT_W:0] sat_add(
        input logic [lce_pkg::COUNT_W-1:0] a,
        input logic [lce_pkg::COUNT_W-1:0] b
    );
        logic [lce_pkg::COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[lce_pkg::COUNT_W]) begin
            s = {1'b1, lce_pkg::COUNT_MAX};
        end
        return s;
    endfunction

    logic [1:0]                         r_state, n_state;
    logic [FILL_W-1:0]                  r_fill, n_fill;
    logic [FILL_W-1:0]                  r_idx, n_idx;
    logic                               r_rd_vld, n_rd_vld;
    logic signed [lce_pkg::VALUE_W-1:0] r_val, n_val;
    logic                               r_last, n_last;
    logic [LEN_W-1:0]                   r_len, n_len;
    logic [lce_pkg::COUNT_W-1:0]        r_cnt, n_cnt;
    logic [LEN_W-1:0]                   r_best_len, n_best_len;
    logic [lce_pkg::COUNT_W-1:0]        r_best_tot, n_best_tot;
    logic                               r_sat, n_sat;
    logic                               r_ovf, n_ovf;
    logic                               r_out_vld, n_out_vld;
    logic [lce_pkg::COUNT_W-1:0]        r_out_cnt, n_out_cnt;
    logic [lce_pkg::LENGTH_W-1:0]       r_out_len, n_out_len;
    logic                               r_out_sat, n_out_sat;
    logic                               r_out_ovf, n_out_ovf;

    logic                               issue;
    logic                               in_acc;
    logic                               out_free;
    logic                               ram_we;
    logic                               ram_re;
    logic [WORD_W-1:0]                  ram_q;
    logic [WORD_W-1:0]                  ram_d;
    logic signed [lce_pkg::VALUE_W-1:0] rd_val;
    logic [LEN_W-1:0]                   rd_len;
    logic [lce_pkg::COUNT_W-1:0]        rd_cnt;
    logic [LEN_W-1:0]                   cand;
    logic [lce_pkg::COUNT_W:0]          tie_sum;
    logic [lce_pkg::COUNT_W:0]          best_sum;
    logic [LEN_W+lce_pkg::LENGTH_W-1:0] len_ext;

    assign issue    = (r_idx != r_fill);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign ram_re   = (r_state == S_SCAN) && issue;
    assign ram_we   = (r_state == S_WRITE);
    assign ram_d    = {r_val, r_len, r_cnt};

    assign rd_cnt = ram_q[lce_pkg::COUNT_W-1:0];
    assign rd_len = ram_q[lce_pkg::COUNT_W +: LEN_W];
    assign rd_val = ram_q[lce_pkg::COUNT_W+LEN_W +: lce_pkg::VALUE_W];

    assign cand     = rd_len + LEN_W'(1);
    assign tie_sum  = sat_add(r_cnt, rd_cnt);
    assign best_sum = sat_add(r_best_tot, r_cnt);
    assign len_ext  = {{lce_pkg::LENGTH_W{1'b0}}, r_best_len};

    lce_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LEN)
    ) u_lce_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (ram_d),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_val      = r_val;
        n_last     = r_last;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_best_len = r_best_len;
        n_best_tot = r_best_tot;
        n_sat      = r_sat;
        n_ovf      = r_ovf;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_cnt  = r_out_cnt;
        n_out_len  = r_out_len;
        n_out_sat  = r_out_sat;
        n_out_ovf  = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val  = i_in.value;
                    n_last = i_in.last;
                    n_len  = LEN_W'(1);
                    n_cnt  = lce_pkg::COUNT_W'(1);
                    n_idx  = '0;
                    if (r_fill == FILL_FULL) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else if (r_fill == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx    = r_idx + FILL_W'(1);
                    n_rd_vld = 1'b1;
                end else begin
                    n_state = S_WRITE;
                end
                if (r_rd_vld && (rd_val < r_val)) begin
                    if (cand > r_len) begin
                        n_len = cand;
                        n_cnt = rd_cnt;
                    end else if (cand == r_len) begin
                        n_cnt = tie_sum[lce_pkg::COUNT_W-1:0];
                        if (tie_sum[lce_pkg::COUNT_W]) begin
                            n_sat = 1'b1;
                        end
                    end
                end
            end
            S_WRITE: begin
                n_fill = r_fill + FILL_W'(1);
                if (r_len > r_best_len) begin
                    n_best_len = r_len;
                    n_best_tot = r_cnt;
                end else if (r_len == r_best_len) begin
                    n_best_tot = best_sum[lce_pkg::COUNT_W-1:0];
                    if (best_sum[lce_pkg::COUNT_W]) begin
                        n_sat = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_cnt  = r_best_tot;
                    n_out_len  = len_ext[lce_pkg::LENGTH_W-1:0];
                    n_out_sat  = r_sat;
                    n_out_ovf  = r_ovf;
                    n_fill     = '0;
                    n_best_len = '0;
                    n_best_tot = '0;
                    n_sat      = 1'b0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_best_len <= '0;
            r_best_tot <= '0;
            r_sat      <= 1'b0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_rd_vld   <= n_rd_vld;
            r_best_len <= n_best_len;
            r_best_tot <= n_best_tot;
            r_sat      <= n_sat;
            r_ovf      <= n_ovf;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_last    <= n_last;
        r_len     <= n_len;
        r_cnt     <= n_cnt;
        r_out_cnt <= n_out_cnt;
        r_out_len <= n_out_len;
        r_out_sat <= n_out_sat;
        r_out_ovf <= n_out_ovf;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_vld;
    assign o_out.lis_count       = r_out_cnt;
    assign o_out.lis_length      = r_out_len;
    assign o_out.count_saturated = r_out_sat;
    assign o_out.too_long        = r_out_ovf;

endmodule

FILE: hdl/lce_checker.sv
// port-level assertions for the lis count engine and their binding
module lce_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [lce_pkg::COUNT_W-1:0]      i_out_count,
    input logic [lce_pkg::LENGTH_W-1:0]     i_out_length,
    input logic                             i_out_sat,
    input logic                             i_out_ovf
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_count) && $stable(i_out_length) &&
            $stable(i_out_sat) && $stable(i_out_ovf))
        else $error("result word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count != '0)
        else $error("result carries a zero count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous word still in work");

endmodule

bind lis_count_engine lce_checker u_lce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_count  (o_out.lis_count),
    .i_out_length (o_out.lis_length),
    .i_out_sat    (o_out.count_saturated),
    .i_out_ovf    (o_out.too_long)
);
